/* rtl/tyb2i420_pkg.sv */
package tyb2i420_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_CHROMA_ORDER = 2'd2
	} cfg_reg_t;

	// register reset values
	localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
	localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
	localparam logic        RST_CHROMA_ORDER = 1'b1;

	// field and state widths
	localparam int DIM_W  = 12;              // frame dimensions
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 23;
	localparam int OFF_W  = 8;               // byte offset inside a block
	localparam int TX_W   = DIM_W;           // tile column, always below the width
	localparam int BD_W   = 18;              // blocks per frame stay below 2^18
	localparam int TY_W   = BD_W + 3;        // at most eight rows per block
	localparam int FS_W   = 2 * DIM_W;       // luma plane size
	localparam int TOT_W  = FS_W + 1;        // luma plus chroma size

	// block layout
	localparam logic [OFF_W-1:0] BLOCK_LAST = 8'd191;
	localparam int TILE_W = 16;
	localparam int TILE_H = 8;

	typedef enum logic [1:0] {
		PLANE_LUMA   = 2'd0,
		PLANE_FIRST  = 2'd1,
		PLANE_SECOND = 2'd2
	} plane_t;

endpackage

/* rtl/tiled_yuv_block_to_planar_i420_core.sv */
// Tiled camera YUV 4:2:0 stream to planar I420 address generator.
//
// Input stream (s_*): one raw camera byte per beat in s_tdata. The stream is a
// run of 192-byte blocks: 128 luma bytes of a 16x8 tile (left 8x8 half, then
// right half), then 32 U and 32 V bytes of the 8x4 chroma tile, in the configured order.
// Output stream (m_*): one beat per input beat with the I420 byte address,
// the byte, the plane and an in-frame flag; m_tlast marks the last byte of
// the frame's final block, after which the tile position starts over.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 width,
// 1 height, 2 chroma order); write only while no beat is in flight.
// Each beat passes the input register, then the result register. Throughput
// is one beat per cycle while m_tready stays high; the address path is one
// 12x12 multiply and a three-way add between the two registers.
// A stalled receiver holds the result register; the input register keeps
// accepting until it too is full, and then s_tready falls.
// Reset empties both registers, returns the tile position to the frame origin
// and loads width 640, height 480 and V-first chroma order.
module tiled_yuv_block_to_planar_i420_core
	import tyb2i420_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] raw_byte
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [22:0] dest_address, [30:23] pixel_byte
	output logic [2:0]            m_tuser,   // [1:0] plane, [2] in_frame
	output logic                  m_tlast    // frame_last
);

	// configuration registers
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic             chroma_order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			chroma_order_q <= RST_CHROMA_ORDER;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[DIM_W-1:0];
				REG_CHROMA_ORDER: chroma_order_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamp dimensions to the supported maximum
	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [DIM_W-2:0] hw;
	logic [DIM_W-2:0] hh;

	assign w  = (32'(frame_width_q) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_q;
	assign h  = (32'(frame_height_q) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_q;
	assign hw = w[DIM_W-1:1];
	assign hh = h[DIM_W-1:1];

	// dimensions as they will stand after this edge's register write
	logic [DIM_W-1:0] width_d;
	logic [DIM_W-1:0] height_d;
	logic [DIM_W-1:0] w_d;
	logic [DIM_W-1:0] h_d;

	assign width_d  = (cfg_we && (cfg_addr == REG_FRAME_WIDTH)) ?
		cfg_wdata[DIM_W-1:0] : frame_width_q;
	assign height_d = (cfg_we && (cfg_addr == REG_FRAME_HEIGHT)) ?
		cfg_wdata[DIM_W-1:0] : frame_height_q;
	assign w_d = (32'(width_d) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_d;
	assign h_d = (32'(height_d) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_d;

	// plane sizes, loaded together with the dimension registers
	logic [FS_W-1:0]  fs_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] second_base_q;
	logic [FS_W-1:0]  fs_next;

	assign fs_next = FS_W'(w_d) * FS_W'(h_d);

	always_ff @(posedge clk) begin
		fs_q          <= fs_next;
		total_q       <= TOT_W'(fs_next) + TOT_W'(fs_next >> 1);
		second_base_q <= TOT_W'(fs_next) + TOT_W'(fs_next >> 2);
	end

	// pipeline handshake
	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	logic adv_s2;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	// input register
	logic [BYTE_W-1:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// tile position state
	logic [OFF_W-1:0] block_offset_q;
	logic [TX_W-1:0]  tile_x_q;
	logic [TY_W-1:0]  tile_y_q;
	logic [BD_W-1:0]  blocks_done_q;

	// per-byte coordinates
	logic              is_luma;
	logic              first;
	logic [TX_W:0]     rx;
	logic [TY_W:0]     ry;
	logic [TX_W-1:0]   cx;
	logic [TY_W-1:0]   cy;
	logic              luma_in;
	logic              chroma_in;
	logic              in_frm;

	assign is_luma = !block_offset_q[7];
	// chroma bytes fill offsets 128..159 and 160..191; order 0 sends 128..159 to U, order 1 to V
	assign first   = block_offset_q[5] ? chroma_order_q : !chroma_order_q;
	assign rx      = {1'b0, tile_x_q} + (TX_W+1)'(block_offset_q[2:0])
		+ (TX_W+1)'({block_offset_q[6], 3'b000});
	assign ry      = {1'b0, tile_y_q} + (TY_W+1)'(block_offset_q[5:3]);
	assign cx      = TX_W'(tile_x_q[TX_W-1:1]) + TX_W'(block_offset_q[2:0]);
	assign cy      = TY_W'(tile_y_q[TY_W-1:1]) + TY_W'(block_offset_q[4:3]);

	assign luma_in   = (rx < (TX_W+1)'(w)) && (ry < (TY_W+1)'(h));
	assign chroma_in = (cx < TX_W'(hw)) && (cy < TY_W'(hh));
	assign in_frm    = is_luma ? luma_in : chroma_in;

	// address: row times pitch plus column plus plane base
	logic [DIM_W-1:0]  mul_row;
	logic [DIM_W-1:0]  mul_pitch;
	logic [FS_W-1:0]   row_off;
	logic [TX_W:0]     col;
	logic [TOT_W-1:0]  base;
	logic [TOT_W:0]    addr_sum;
	logic [ADDR_W-1:0] addr;
	plane_t            plane;

	// rows beyond the 12-bit range are outside the frame and give address zero
	assign mul_row   = is_luma ? ry[DIM_W-1:0] : cy[DIM_W-1:0];
	assign mul_pitch = is_luma ? w : {1'b0, hw};
	assign row_off   = FS_W'(mul_row) * FS_W'(mul_pitch);
	assign col       = is_luma ? rx : {1'b0, cx};
	assign base      = is_luma ? '0 : (first ? TOT_W'(fs_q) : second_base_q);
	assign addr_sum  = (TOT_W+1)'(row_off) + (TOT_W+1)'(col) + (TOT_W+1)'(base);
	assign addr      = in_frm ? addr_sum[ADDR_W-1:0] : '0;
	assign plane     = is_luma ? PLANE_LUMA : (first ? PLANE_FIRST : PLANE_SECOND);

	// end of block and end of frame
	logic              block_end;
	logic [BD_W:0]     bd_inc;
	logic [BD_W+8:0]   bytes_done;
	logic              last_block;
	logic [TX_W:0]     tile_x_adv;
	logic              wrap;

	assign block_end  = (block_offset_q == BLOCK_LAST);
	assign bd_inc     = (BD_W+1)'(blocks_done_q) + (BD_W+1)'(1);
	// times 192 as two shifts
	assign bytes_done = ((BD_W+9)'(bd_inc) << 7) + ((BD_W+9)'(bd_inc) << 6);
	assign last_block = bytes_done >= (BD_W+9)'(total_q);
	assign tile_x_adv = {1'b0, tile_x_q} + (TX_W+1)'(TILE_W);
	assign wrap       = tile_x_adv >= (TX_W+1)'(w);

	// advance the tile position as each byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_offset_q <= '0;
			tile_x_q       <= '0;
			tile_y_q       <= '0;
			blocks_done_q  <= '0;
		end else if (adv_s1) begin
			if (block_end) begin
				block_offset_q <= '0;
				if (last_block) begin
					tile_x_q      <= '0;
					tile_y_q      <= '0;
					blocks_done_q <= '0;
				end else begin
					blocks_done_q <= bd_inc[BD_W-1:0];
					if (wrap) begin
						tile_x_q <= '0;
						tile_y_q <= tile_y_q + TY_W'(TILE_H);
					end else begin
						tile_x_q <= tile_x_adv[TX_W-1:0];
					end
				end
			end else begin
				block_offset_q <= block_offset_q + OFF_W'(1);
			end
		end
	end

	// result register
	logic [ADDR_W-1:0] addr_s2;
	logic [BYTE_W-1:0] byte_s2;
	plane_t            plane_s2;
	logic              in_frame_s2;
	logic              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			addr_s2     <= addr;
			byte_s2     <= byte_s1;
			plane_s2    <= plane;
			in_frame_s2 <= in_frm;
			last_s2     <= block_end && last_block;
		end
	end

	// output beat
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, byte_s2, addr_s2};
	assign m_tuser  = {in_frame_s2, plane_s2};
	assign m_tlast  = last_s2;

endmodule
